>>> rtl/core/olb_pkg.sv
// Shared types and constants of the overlap linear blend block.
package olb_pkg;

   localparam int COL_W     = 13;
   localparam int PIX_W     = 8;
   localparam int CSR_W     = 13;
   localparam int CSR_IDX_W = 1;
   localparam int REGION_W  = 2;

   localparam int CSR_MAX           = (1 << CSR_W) - 1;
   localparam int MAX_WIDTH_DEFAULT = 4096;

   localparam logic [CSR_W-1:0] WIDTH_RESET = 13'd640;
   localparam logic [CSR_W-1:0] SHIFT_RESET = 13'd320;

   typedef enum logic [REGION_W-1:0] {
      REGION_LEFT    = 2'd0,
      REGION_BLEND   = 2'd1,
      REGION_RIGHT   = 2'd2,
      REGION_OUTSIDE = 2'd3
   } region_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH = 1'b0,
      CSR_SHIFT_X     = 1'b1
   } csr_index_type;

   // Control that travels with each pipeline slot.
   typedef struct packed {
      logic       valid;
      region_type region;
   } stage_tag_type;

endpackage

>>> rtl/core/olb_if.sv
// Request and response channel interfaces of the overlap linear blend block.
interface olb_req_if;
   import olb_pkg::*;
   logic             valid;
   logic             ready;
   logic [COL_W-1:0] column;
   logic [PIX_W-1:0] left_pixel;
   logic [PIX_W-1:0] right_pixel;

   modport source (output valid, column, left_pixel, right_pixel, input ready);
   modport sink   (input valid, column, left_pixel, right_pixel, output ready);
endinterface

interface olb_rsp_if;
   import olb_pkg::*;
   logic                valid;
   logic                ready;
   logic [PIX_W-1:0]    pixel;
   logic [REGION_W-1:0] region;

   modport source (output valid, pixel, region, input ready);
   modport sink   (input valid, pixel, region, output ready);
endinterface

>>> rtl/core/olb_cfg.sv
// Configuration registers and the derived width, shift, right end and divisor.
module olb_cfg #(
   parameter int EFF_MAX = olb_pkg::MAX_WIDTH_DEFAULT,
   parameter int WB      = $clog2(EFF_MAX + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [olb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [olb_pkg::CSR_W-1:0]      csr_data,
   output logic [WB-1:0]                  w_eff,
   output logic [WB-1:0]                  s_eff,
   output logic [WB:0]                    ws_sum,
   output logic [WB-1:0]                  d_div
);
   import olb_pkg::*;

   logic [CSR_W-1:0] width_raw_ff;
   logic [CSR_W-1:0] shift_raw_ff;
   logic [CSR_W-1:0] w_full;
   logic [CSR_W-1:0] s_full;
   logic [WB-1:0]    w_ff, w_in;
   logic [WB-1:0]    s_ff, s_in;
   logic [WB:0]      ws_ff, ws_in;
   logic [WB-1:0]    d_ff, d_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_raw_ff <= WIDTH_RESET;
         shift_raw_ff <= SHIFT_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH: width_raw_ff <= csr_data;
            CSR_SHIFT_X:     shift_raw_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // zero width acts as one; width saturates at the build limit; shift clamps to width
   always_comb begin
      if (width_raw_ff == '0)
         w_full = CSR_W'(1);
      else if (width_raw_ff > CSR_W'(EFF_MAX))
         w_full = CSR_W'(EFF_MAX);
      else
         w_full = width_raw_ff;
      s_full = (shift_raw_ff > w_full) ? w_full : shift_raw_ff;
      w_in   = WB'(w_full);
      s_in   = WB'(s_full);
      ws_in  = (WB+1)'(w_full) + (WB+1)'(s_full);
      d_in   = WB'(w_full - s_full);
   end

   always_ff @(posedge clock) begin
      w_ff  <= w_in;
      s_ff  <= s_in;
      ws_ff <= ws_in;
      d_ff  <= d_in;
   end

   assign w_eff  = w_ff;
   assign s_eff  = s_ff;
   assign ws_sum = ws_ff;
   assign d_div  = d_ff;

endmodule

>>> rtl/core/olb_front.sv
// Front stages: input register, region decode, weight products, numerator sum.
module olb_front #(
   parameter int WB = 13
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   olb_req_if.sink                       req_port,
   input  logic [WB-1:0]                 w_eff,
   input  logic [WB-1:0]                 s_eff,
   input  logic [WB:0]                   ws_sum,
   output olb_pkg::stage_tag_type        tag_out,
   output logic [WB+olb_pkg::PIX_W-1:0]  num_out,
   output logic [olb_pkg::PIX_W-1:0]     q_out
);
   import olb_pkg::*;

   localparam int NW = WB + PIX_W;

   // stage 1: registered transaction
   logic             v1_ff;
   logic [COL_W-1:0] col1_ff;
   logic [PIX_W-1:0] lp1_ff, rp1_ff;

   // stage 2: region and distances to the overlap edges
   stage_tag_type    tag2_ff, tag2_in;
   logic [WB-1:0]    dl2_ff, dl2_in, dr2_ff, dr2_in;
   logic [PIX_W-1:0] lp2_ff, rp2_ff, copy2_ff, copy2_in;

   // stage 3: weighted products
   stage_tag_type    tag3_ff;
   logic [NW-1:0]    pl3_ff, pl3_in, pr3_ff, pr3_in;
   logic [PIX_W-1:0] copy3_ff;

   // stage 4: numerator
   stage_tag_type    tag4_ff;
   logic [NW-1:0]    num4_ff, num4_in;
   logic [PIX_W-1:0] q4_ff, q4_in;

   assign req_port.ready = en;

   always_comb begin
      if (col1_ff < COL_W'(s_eff))
         tag2_in.region = REGION_LEFT;
      else if (col1_ff < COL_W'(w_eff))
         tag2_in.region = REGION_BLEND;
      else if ({1'b0, col1_ff} < (COL_W+1)'(ws_sum))
         tag2_in.region = REGION_RIGHT;
      else
         tag2_in.region = REGION_OUTSIDE;
      tag2_in.valid = v1_ff;
      dl2_in = WB'(COL_W'(w_eff) - col1_ff);
      dr2_in = WB'(col1_ff - COL_W'(s_eff));
      case (tag2_in.region)
         REGION_LEFT:  copy2_in = lp1_ff;
         REGION_RIGHT: copy2_in = rp1_ff;
         default:      copy2_in = '0;
      endcase
   end

   assign pl3_in  = NW'(dl2_ff) * NW'(lp2_ff);
   assign pr3_in  = NW'(dr2_ff) * NW'(rp2_ff);
   assign num4_in = pl3_ff + pr3_ff;
   assign q4_in   = (tag3_ff.region == REGION_BLEND) ? '0 : copy3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
         tag4_ff.valid <= 1'b0;
      end else if (en) begin
         v1_ff   <= req_port.valid;
         tag2_ff <= tag2_in;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         col1_ff  <= req_port.column;
         lp1_ff   <= req_port.left_pixel;
         rp1_ff   <= req_port.right_pixel;
         dl2_ff   <= dl2_in;
         dr2_ff   <= dr2_in;
         lp2_ff   <= lp1_ff;
         rp2_ff   <= rp1_ff;
         copy2_ff <= copy2_in;
         pl3_ff   <= pl3_in;
         pr3_ff   <= pr3_in;
         copy3_ff <= copy2_ff;
         num4_ff  <= num4_in;
         q4_ff    <= q4_in;
      end
   end

   assign tag_out = tag4_ff;
   assign num_out = num4_ff;
   assign q_out   = q4_ff;

endmodule

>>> rtl/core/olb_div_step.sv
// One restoring division stage: resolves one quotient bit of the blend.
module olb_div_step #(
   parameter int WB    = 13,
   parameter int SHIFT = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic [WB-1:0]                 d_div,
   input  olb_pkg::stage_tag_type        prev_tag,
   input  logic [WB+olb_pkg::PIX_W-1:0]  prev_rem,
   input  logic [olb_pkg::PIX_W-1:0]     prev_q,
   output olb_pkg::stage_tag_type        tag,
   output logic [WB+olb_pkg::PIX_W-1:0]  rem,
   output logic [olb_pkg::PIX_W-1:0]     q
);
   import olb_pkg::*;

   localparam int NW = WB + PIX_W;

   stage_tag_type    tag_ff;
   logic [NW-1:0]    rem_ff, rem_in;
   logic [PIX_W-1:0] q_ff, q_in;
   logic [NW-1:0]    dsh;
   logic             take;

   // copy regions carry their pixel in q and pass untouched
   always_comb begin
      dsh  = NW'(d_div) << SHIFT;
      take = (prev_tag.region == REGION_BLEND) && (prev_rem >= dsh);
      rem_in = take ? (prev_rem - dsh) : prev_rem;
      q_in = prev_q;
      q_in[SHIFT] = prev_q[SHIFT] | take;
   end

   always_ff @(posedge clock) begin
      if (reset)
         tag_ff.valid <= 1'b0;
      else if (en)
         tag_ff <= prev_tag;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   assign tag = tag_ff;
   assign rem = rem_ff;
   assign q   = q_ff;

endmodule

>>> rtl/core/olb_skid.sv
// Output register with a skid entry; the pipeline advances while the skid is empty.
module olb_skid (
   input  logic                       clock,
   input  logic                       reset,
   input  olb_pkg::stage_tag_type     prev_tag,
   input  logic [olb_pkg::PIX_W-1:0]  prev_q,
   output logic                       in_ready,
   olb_rsp_if.source                  rsp_port
);
   import olb_pkg::*;

   logic             out_v_ff, skid_v_ff;
   logic [PIX_W-1:0] out_pix_ff, skid_pix_ff;
   region_type       out_reg_ff, skid_reg_ff;
   logic             load;

   assign load     = rsp_port.ready || !out_v_ff;
   assign in_ready = !skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (load) begin
         out_v_ff  <= skid_v_ff || prev_tag.valid;
         skid_v_ff <= 1'b0;
      end else if (prev_tag.valid && !skid_v_ff) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_pix_ff <= skid_v_ff ? skid_pix_ff : prev_q;
         out_reg_ff <= skid_v_ff ? skid_reg_ff : prev_tag.region;
      end else if (!skid_v_ff) begin
         skid_pix_ff <= prev_q;
         skid_reg_ff <= prev_tag.region;
      end
   end

   assign rsp_port.valid  = out_v_ff;
   assign rsp_port.pixel  = out_pix_ff;
   assign rsp_port.region = out_reg_ff;

endmodule

>>> rtl/core/overlap_linear_blend.sv
// Top level of the overlap linear blend block: two-image stitch pixel with feathered overlap.
//
//   channel  | dir | payload                              | handshake
//   ---------+-----+--------------------------------------+-----------------
//   req_port | in  | column, left_pixel, right_pixel      | valid / ready
//   rsp_port | out | pixel, region                        | valid / ready
//   csr_*    | in  | csr_index, csr_data                  | csr_write strobe
//
// One transaction per clock sustained while responses are taken. A result
// crosses thirteen registers after its request is taken, the first loaded at the
// accepting edge: input register, region decode, products, numerator sum,
// eight restoring divider stages (one quotient bit each), output register.
// The divider chain sets the depth; the 13x8 product stage sets the clock.
// Reset clears all valid bits and loads the width and shift defaults; derived
// config is registered again from the written csr value.
// A stalled response fills the skid entry; while it is full every stage before the output register holds.
module overlap_linear_blend #(
   parameter int MAX_WIDTH = olb_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   olb_req_if.sink                       req_port,
   olb_rsp_if.source                     rsp_port,
   input  logic                          csr_write,
   input  logic [olb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [olb_pkg::CSR_W-1:0]     csr_data
);
   import olb_pkg::*;

   // the width register is 13 bits, so the usable width never tops CSR_MAX
   localparam int EFF_MAX = (MAX_WIDTH < CSR_MAX) ? MAX_WIDTH : CSR_MAX;
   localparam int WB      = $clog2(EFF_MAX + 1);
   localparam int NW      = WB + PIX_W;

   logic [WB-1:0] w_eff, s_eff, d_div;
   logic [WB:0]   ws_sum;
   logic          pipe_en;

   stage_tag_type    tag_chain [PIX_W+1];
   logic [NW-1:0]    rem_chain [PIX_W+1];
   logic [PIX_W-1:0] q_chain   [PIX_W+1];

   olb_cfg #(
      .EFF_MAX (EFF_MAX),
      .WB      (WB)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .w_eff     (w_eff),
      .s_eff     (s_eff),
      .ws_sum    (ws_sum),
      .d_div     (d_div)
   );

   olb_front #(
      .WB (WB)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .req_port (req_port),
      .w_eff    (w_eff),
      .s_eff    (s_eff),
      .ws_sum   (ws_sum),
      .tag_out  (tag_chain[0]),
      .num_out  (rem_chain[0]),
      .q_out    (q_chain[0])
   );

   // quotient fits in PIX_W bits since the numerator never reaches 256 * divisor
   for (genvar i = 0; i < PIX_W; i++) begin : g_div
      olb_div_step #(
         .WB    (WB),
         .SHIFT (PIX_W - 1 - i)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .en       (pipe_en),
         .d_div    (d_div),
         .prev_tag (tag_chain[i]),
         .prev_rem (rem_chain[i]),
         .prev_q   (q_chain[i]),
         .tag      (tag_chain[i+1]),
         .rem      (rem_chain[i+1]),
         .q        (q_chain[i+1])
      );
   end

   olb_skid u_skid (
      .clock    (clock),
      .reset    (reset),
      .prev_tag (tag_chain[PIX_W]),
      .prev_q   (q_chain[PIX_W]),
      .in_ready (pipe_en),
      .rsp_port (rsp_port)
   );

   // outside columns always read as black
   a_outside_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && rsp_port.region == REGION_OUTSIDE) |-> (rsp_port.pixel == '0))
      else $error("outside result with nonzero pixel");

   // a held pipeline implies a response is waiting downstream
   a_stall_has_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_port.ready |-> rsp_port.valid)
      else $error("pipeline held with no pending response");

   // nothing is presented right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_port.valid)
      else $error("response valid after reset");

   // the pipeline only holds while a response is refused
   a_hold_cause: assert property (@(posedge clock) disable iff (reset)
      (pipe_en && !$past(pipe_en) && !$past(reset)) |-> $past(rsp_port.ready))
      else $error("skid drained without response taken");

endmodule
